[rtl/core/tq_pkg.sv]
`timescale 1ns / 1ps

package tq_pkg;

  // Default sizes of the queue and of the timer table
  localparam int QUEUE_SLOTS_DEF = 9;
  localparam int TIMER_SLOTS_DEF = 9;

  // Field widths
  localparam int ID_W    = 8;
  localparam int DELAY_W = 16;
  localparam int FIRED_W = 4;
  localparam int TENTRY_W = ID_W + DELAY_W;

  localparam logic [FIRED_W-1:0] FIRED_MAX = '1;
  localparam logic [ID_W-1:0]    ID_IDLE   = '0;

  // Operation codes carried by the func field
  typedef enum logic [1:0] {
    FUNC_ADD_TASK  = 2'd0,
    FUNC_ADD_TIMER = 2'd1,
    FUNC_TICK      = 2'd2,
    FUNC_DISPATCH  = 2'd3
  } func_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DECIDE,
    ST_SCAN_RD,
    ST_SCAN_CHK,
    ST_ARM,
    ST_POP_TAKE,
    ST_DONE
  } state_t;

  // Controller to datapath
  typedef struct packed {
    logic load_item;
    logic enq_item;
    logic scan_chk;
    logic arm;
    logic pop_take;
    logic out_load;
  } tq_cmd_t;

  // Datapath to controller
  typedef struct packed {
    func_t func;
    logic  id_zero;
    logic  delay_zero;
    logic  scan_last;
    logic  queue_empty;
    logic  out_free;
  } tq_sts_t;

endpackage

[rtl/core/tq_ram.sv]
`timescale 1ns / 1ps

module tq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 9,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  // Write port and registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    rd_data_r <= mem_r[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

[rtl/core/tq_dp.sv]
`timescale 1ns / 1ps

module tq_dp
  import tq_pkg::*;
#(
  parameter int QUEUE_SLOTS = QUEUE_SLOTS_DEF,
  parameter int TIMER_SLOTS = TIMER_SLOTS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  tq_cmd_t            cmd,
  output tq_sts_t            sts,
  input  logic [1:0]         in_func,
  input  logic [ID_W-1:0]    in_task_id,
  input  logic [DELAY_W-1:0] in_delay_ticks,
  input  logic               in_update_existing,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [ID_W-1:0]    out_run_task,
  output logic               out_accepted,
  output logic [FIRED_W-1:0] out_fired_count
);

  localparam int QW  = (QUEUE_SLOTS > 1) ? $clog2(QUEUE_SLOTS) : 1;
  localparam int QCW = $clog2(QUEUE_SLOTS + 1);
  localparam int TW  = (TIMER_SLOTS > 1) ? $clog2(TIMER_SLOTS) : 1;

  // Captured item
  func_t              item_func_r;
  logic [ID_W-1:0]    item_id_r;
  logic [DELAY_W-1:0] item_delay_r;
  logic               item_update_r;

  // Queue pointers
  logic [QW-1:0]  head_r, head_nxt, tail_r, tail_nxt;
  logic [QCW-1:0] count_r, count_nxt;

  // Timer scan state
  logic [TIMER_SLOTS-1:0] used_r, used_nxt;
  logic [TW-1:0]          scan_idx_r, scan_idx_nxt;
  logic [TW-1:0]          match_idx_r, match_idx_nxt, free_idx_r, free_idx_nxt;
  logic                   match_found_r, match_found_nxt, free_found_r, free_found_nxt;

  // Result of the current item and output register
  logic [ID_W-1:0]    run_r, run_nxt;
  logic               acc_r, acc_nxt;
  logic [FIRED_W-1:0] fired_r, fired_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic [ID_W-1:0]    out_run_r;
  logic               out_acc_r;
  logic [FIRED_W-1:0] out_fired_r;

  // Memory ports
  logic                q_we;
  logic [ID_W-1:0]     q_wdata, q_rdata;
  logic                t_we;
  logic [TW-1:0]       t_waddr;
  logic [TENTRY_W-1:0] t_wdata, t_rdata;

  logic [ID_W-1:0]    t_owner;
  logic [DELAY_W-1:0] t_remain;
  logic               cur_used;
  logic               queue_full;
  logic               enq_req, enq_ok;
  logic [ID_W-1:0]    enq_id;

  assign t_owner    = t_rdata[TENTRY_W-1:DELAY_W];
  assign t_remain   = t_rdata[DELAY_W-1:0];
  assign cur_used   = used_r[scan_idx_r];
  assign queue_full = (count_r == QCW'(QUEUE_SLOTS));

  tq_ram #(.WIDTH(ID_W), .DEPTH(QUEUE_SLOTS), .AW(QW)) u_queue_ram (
    .clk     (clk),
    .wr_en   (q_we),
    .wr_addr (tail_r),
    .wr_data (q_wdata),
    .rd_addr (head_r),
    .rd_data (q_rdata)
  );

  tq_ram #(.WIDTH(TENTRY_W), .DEPTH(TIMER_SLOTS), .AW(TW)) u_timer_ram (
    .clk     (clk),
    .wr_en   (t_we),
    .wr_addr (t_waddr),
    .wr_data (t_wdata),
    .rd_addr (scan_idx_r),
    .rd_data (t_rdata)
  );

  // Pick the task to enqueue: the captured item or an expiring timer
  always_comb begin
    enq_req = 1'b0;
    enq_id  = item_id_r;
    if (cmd.enq_item) begin
      enq_req = 1'b1;
    end else if (cmd.scan_chk && item_func_r == FUNC_TICK && cur_used &&
                 t_remain == '0) begin
      enq_req = 1'b1;
      enq_id  = t_owner;
    end
    enq_ok  = enq_req && enq_id != ID_IDLE && !queue_full;
    q_we    = enq_ok;
    q_wdata = enq_id;
  end

  // Queue pointers: push at tail, pop at head
  always_comb begin
    head_nxt  = head_r;
    tail_nxt  = tail_r;
    count_nxt = count_r;
    if (enq_ok) begin
      tail_nxt  = (tail_r == QW'(QUEUE_SLOTS - 1)) ? '0 : tail_r + QW'(1);
      count_nxt = count_r + QCW'(1);
    end
    if (cmd.pop_take) begin
      head_nxt  = (head_r == QW'(QUEUE_SLOTS - 1)) ? '0 : head_r + QW'(1);
      count_nxt = count_r - QCW'(1);
    end
  end

  // Timer scan, arm and result bookkeeping
  always_comb begin
    used_nxt        = used_r;
    scan_idx_nxt    = scan_idx_r;
    match_idx_nxt   = match_idx_r;
    match_found_nxt = match_found_r;
    free_idx_nxt    = free_idx_r;
    free_found_nxt  = free_found_r;
    run_nxt         = run_r;
    acc_nxt         = acc_r;
    fired_nxt       = fired_r;
    t_we            = 1'b0;
    t_waddr         = scan_idx_r;
    t_wdata         = {t_owner, t_remain - DELAY_W'(1)};

    if (cmd.load_item) begin
      scan_idx_nxt    = '0;
      match_found_nxt = 1'b0;
      free_found_nxt  = 1'b0;
      run_nxt         = '0;
      acc_nxt         = 1'b0;
      fired_nxt       = '0;
    end

    if (cmd.enq_item) begin
      acc_nxt = enq_ok;
    end

    if (cmd.scan_chk) begin
      if (item_func_r == FUNC_TICK) begin
        // Count down an armed timer, or fire it and free the slot
        if (cur_used) begin
          if (t_remain != '0) begin
            t_we = 1'b1;
          end else begin
            used_nxt[scan_idx_r] = 1'b0;
            if (fired_r != FIRED_MAX) begin
              fired_nxt = fired_r + FIRED_W'(1);
            end
          end
        end
      end else begin
        // Note the first matching slot (when updating) and the first free slot
        if (item_update_r && cur_used && t_owner == item_id_r && !match_found_r) begin
          match_found_nxt = 1'b1;
          match_idx_nxt   = scan_idx_r;
        end
        if (!cur_used && !free_found_r) begin
          free_found_nxt = 1'b1;
          free_idx_nxt   = scan_idx_r;
        end
      end
      if (scan_idx_r != TW'(TIMER_SLOTS - 1)) begin
        scan_idx_nxt = scan_idx_r + TW'(1);
      end
    end

    if (cmd.arm) begin
      t_wdata = {item_id_r, item_delay_r - DELAY_W'(1)};
      if (match_found_r) begin
        t_we    = 1'b1;
        t_waddr = match_idx_r;
        acc_nxt = 1'b1;
      end else if (free_found_r) begin
        t_we                 = 1'b1;
        t_waddr              = free_idx_r;
        used_nxt[free_idx_r] = 1'b1;
        acc_nxt              = 1'b1;
      end
    end

    if (cmd.pop_take) begin
      run_nxt = q_rdata;
    end
  end

  assign out_valid_nxt = cmd.out_load ? 1'b1 : (out_ready ? 1'b0 : out_valid_r);

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r        <= '0;
      tail_r        <= '0;
      count_r       <= '0;
      used_r        <= '0;
      scan_idx_r    <= '0;
      match_found_r <= 1'b0;
      free_found_r  <= 1'b0;
      out_valid_r   <= 1'b0;
    end else begin
      head_r        <= head_nxt;
      tail_r        <= tail_nxt;
      count_r       <= count_nxt;
      used_r        <= used_nxt;
      scan_idx_r    <= scan_idx_nxt;
      match_found_r <= match_found_nxt;
      free_found_r  <= free_found_nxt;
      out_valid_r   <= out_valid_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      item_func_r   <= func_t'(in_func);
      item_id_r     <= in_task_id;
      item_delay_r  <= in_delay_ticks;
      item_update_r <= in_update_existing;
    end
    match_idx_r <= match_idx_nxt;
    free_idx_r  <= free_idx_nxt;
    run_r       <= run_nxt;
    acc_r       <= acc_nxt;
    fired_r     <= fired_nxt;
    if (cmd.out_load) begin
      out_run_r   <= run_r;
      out_acc_r   <= acc_r;
      out_fired_r <= fired_r;
    end
  end

  assign sts.func        = item_func_r;
  assign sts.id_zero     = (item_id_r == ID_IDLE);
  assign sts.delay_zero  = (item_delay_r == '0);
  assign sts.scan_last   = (scan_idx_r == TW'(TIMER_SLOTS - 1));
  assign sts.queue_empty = (count_r == '0);
  assign sts.out_free    = !out_valid_r || out_ready;

  assign out_valid       = out_valid_r;
  assign out_run_task    = out_run_r;
  assign out_accepted    = out_acc_r;
  assign out_fired_count = out_fired_r;

  // Occupancy never exceeds the slot count
  assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= QCW'(QUEUE_SLOTS))
    else $error("queue count above slot count");

  // Pointers meet whenever the queue is empty or full
  assert property (@(posedge clk) disable iff (!rst_n)
    (head_r != tail_r) |-> (count_r != '0 && !queue_full))
    else $error("queue pointers disagree with count");

  // A pop beat only ever follows a nonempty queue and never comes with a push
  assert property (@(posedge clk) disable iff (!rst_n)
    cmd.pop_take |-> (count_r != '0 && !enq_ok))
    else $error("pop from empty queue or pop during push");

  // Arming a free slot marks it used on the next cycle
  assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.arm && !match_found_r && free_found_r) |=> used_r[$past(free_idx_r)])
    else $error("armed timer slot not marked used");

endmodule

[rtl/core/tq_ctrl.sv]
`timescale 1ns / 1ps

module tq_ctrl
  import tq_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    in_valid,
  output logic    in_ready,
  input  tq_sts_t sts,
  output tq_cmd_t cmd
);

  state_t state_r, state_nxt;

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          state_nxt = ST_DECIDE;
        end
      end
      ST_DECIDE: begin
        case (sts.func)
          FUNC_ADD_TIMER: begin
            if (sts.id_zero || sts.delay_zero) begin
              state_nxt = ST_DONE;
            end else begin
              state_nxt = ST_SCAN_RD;
            end
          end
          FUNC_TICK:     state_nxt = ST_SCAN_RD;
          FUNC_DISPATCH: state_nxt = sts.queue_empty ? ST_DONE : ST_POP_TAKE;
          default:       state_nxt = ST_DONE;
        endcase
      end
      ST_SCAN_RD:  state_nxt = ST_SCAN_CHK;
      ST_SCAN_CHK: begin
        if (!sts.scan_last) begin
          state_nxt = ST_SCAN_RD;
        end else if (sts.func == FUNC_ADD_TIMER) begin
          state_nxt = ST_ARM;
        end else begin
          state_nxt = ST_DONE;
        end
      end
      ST_ARM:      state_nxt = ST_DONE;
      ST_POP_TAKE: state_nxt = ST_DONE;
      ST_DONE: begin
        if (sts.out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default:     state_nxt = ST_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_ready      = 1'b1;
        cmd.load_item = in_valid;
      end
      ST_DECIDE: begin
        case (sts.func)
          FUNC_ADD_TASK:  cmd.enq_item = 1'b1;
          FUNC_ADD_TIMER: cmd.enq_item = !sts.id_zero && sts.delay_zero;
          default:        cmd.enq_item = 1'b0;
        endcase
      end
      ST_SCAN_CHK: cmd.scan_chk = 1'b1;
      ST_ARM:      cmd.arm      = 1'b1;
      ST_POP_TAKE: cmd.pop_take = 1'b1;
      ST_DONE:     cmd.out_load = sts.out_free;
      default:     cmd          = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

[rtl/core/task_queue_with_delay_timers_top.sv]
`timescale 1ns / 1ps

// Cooperative task queue with delay timers. Each input beat carries one
// operation (add task, add timer task, tick, dispatch) and produces exactly
// one result beat. One operation is in flight at a time. Add timer task with
// a nonzero delay and an id that is not idle, and tick, visit every timer
// slot in index order through the timer RAM's registered read port. The
// block is ready for the next input beat in the cycle after the result is
// loaded. The result sits in an output register, so a new input beat is
// taken while the previous result waits; that operation then holds in its
// last cycle until the output register frees.
// Queue entries and timer entries live in RAMs; timer slot occupancy is
// kept in flip-flops, so no clearing pass is needed after reset.
module task_queue_with_delay_timers_top
  import tq_pkg::*;
#(
  parameter int QUEUE_SLOTS = QUEUE_SLOTS_DEF,
  parameter int TIMER_SLOTS = TIMER_SLOTS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [1:0]         in_func,
  input  logic [ID_W-1:0]    in_task_id,
  input  logic [DELAY_W-1:0] in_delay_ticks,
  input  logic               in_update_existing,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [ID_W-1:0]    out_run_task,
  output logic               out_accepted,
  output logic [FIRED_W-1:0] out_fired_count
);

  tq_cmd_t cmd;
  tq_sts_t sts;

  tq_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  tq_dp #(
    .QUEUE_SLOTS (QUEUE_SLOTS),
    .TIMER_SLOTS (TIMER_SLOTS)
  ) u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .cmd                (cmd),
    .sts                (sts),
    .in_func            (in_func),
    .in_task_id         (in_task_id),
    .in_delay_ticks     (in_delay_ticks),
    .in_update_existing (in_update_existing),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_run_task       (out_run_task),
    .out_accepted       (out_accepted),
    .out_fired_count    (out_fired_count)
  );

endmodule

[dv/testbench.sv]
`timescale 1ns / 1ps

module testbench;
  import tq_pkg::*;

  localparam int QDEPTH = QUEUE_SLOTS_DEF;
  localparam int TDEPTH = TIMER_SLOTS_DEF;

  // One operation as offered on the input channel, plus sender pacing
  typedef struct packed {
    func_t              func;
    logic [ID_W-1:0]    id;
    logic [DELAY_W-1:0] delay;
    logic               upd;
    int                 gap;
    bit                 drain;
  } sched_op_t;

  // Response the scheduler owes for one operation
  typedef struct packed {
    logic [ID_W-1:0]    run_task;
    logic               accepted;
    logic [FIRED_W-1:0] fired;
  } sched_result_t;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic [1:0]         in_func = FUNC_ADD_TASK;
  logic [ID_W-1:0]    in_task_id = '0;
  logic [DELAY_W-1:0] in_delay_ticks = '0;
  logic               in_update_existing = 1'b0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic [ID_W-1:0]    out_run_task;
  logic               out_accepted;
  logic [FIRED_W-1:0] out_fired_count;

  // Shadow copy of the run queue and timer table
  logic [ID_W-1:0]    run_q     [QDEPTH];
  logic [ID_W-1:0]    tmr_owner [TDEPTH];
  logic [DELAY_W-1:0] tmr_left  [TDEPTH];

  sched_op_t     op_backlog[$];
  sched_result_t due_results[$];
  sched_op_t     cur_op;
  int            idle_left;
  int            stall_left;
  int            results_seen;
  bit            steady;
  int            mismatches = 0;

  task_queue_with_delay_timers_top #(
    .QUEUE_SLOTS(QDEPTH),
    .TIMER_SLOTS(TDEPTH)
  ) dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_func            (in_func),
    .in_task_id         (in_task_id),
    .in_delay_ticks     (in_delay_ticks),
    .in_update_existing (in_update_existing),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_run_task       (out_run_task),
    .out_accepted       (out_accepted),
    .out_fired_count    (out_fired_count)
  );

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  task automatic report_mismatch(input string msg);
    $display("%0t ERROR %s", $realtime, msg);
    mismatches++;
  endtask

  // Store an id in the first idle queue slot; drop it when the queue is full
  function automatic logic queue_push(input logic [ID_W-1:0] id);
    logic done;
    done = 1'b0;
    if (id != ID_IDLE) begin
      for (int i = 0; i < QDEPTH; i++) begin
        if (!done && run_q[i] == ID_IDLE) begin
          run_q[i] = id;
          done = 1'b1;
        end
      end
    end
    return done;
  endfunction

  // Apply one operation to the shadow state and return its response
  function automatic sched_result_t schedule_op(input sched_op_t op);
    sched_result_t r;
    logic found;
    r = '0;
    found = 1'b0;
    case (op.func)
      FUNC_ADD_TASK: begin
        r.accepted = queue_push(op.id);
      end
      FUNC_ADD_TIMER: begin
        if (op.id == ID_IDLE) begin
          r.accepted = 1'b0;
        end else if (op.delay == '0) begin
          r.accepted = queue_push(op.id);
        end else begin
          // reload the first matching timer, else take the first free one
          if (op.upd) begin
            for (int i = 0; i < TDEPTH; i++) begin
              if (!found && tmr_owner[i] == op.id) begin
                tmr_left[i] = op.delay - 1'b1;
                found = 1'b1;
              end
            end
          end
          for (int i = 0; i < TDEPTH; i++) begin
            if (!found && tmr_owner[i] == ID_IDLE) begin
              tmr_owner[i] = op.id;
              tmr_left[i] = op.delay - 1'b1;
              found = 1'b1;
            end
          end
          r.accepted = found;
        end
      end
      FUNC_TICK: begin
        // count down armed timers; expire the ones already at zero
        for (int i = 0; i < TDEPTH; i++) begin
          if (tmr_owner[i] != ID_IDLE) begin
            if (tmr_left[i] != '0) begin
              tmr_left[i] = tmr_left[i] - 1'b1;
            end else begin
              void'(queue_push(tmr_owner[i]));
              tmr_owner[i] = ID_IDLE;
              if (r.fired != FIRED_MAX) r.fired = r.fired + 1'b1;
            end
          end
        end
      end
      default: begin
        // pop the head and shift the rest forward
        r.run_task = run_q[0];
        if (run_q[0] != ID_IDLE) begin
          for (int i = 0; i + 1 < QDEPTH; i++) run_q[i] = run_q[i + 1];
          run_q[QDEPTH - 1] = ID_IDLE;
        end
      end
    endcase
    return r;
  endfunction

  task automatic push_op(input func_t f, input int id, input int delay, input bit upd,
                         input int gap, input bit drain);
    sched_op_t op;
    op.func  = f;
    op.id    = ID_W'(id);
    op.delay = DELAY_W'(delay);
    op.upd   = upd;
    op.gap   = gap;
    op.drain = drain;
    op_backlog.push_back(op);
  endtask

  // Offer queued operations; predict each one as its beat is taken
  always @(posedge clk) begin : op_driver
    logic nxt_valid;
    if (!rst_n) begin
      in_valid           <= 1'b0;
      in_func            <= FUNC_ADD_TASK;
      in_task_id         <= '0;
      in_delay_ticks     <= '0;
      in_update_existing <= 1'b0;
      idle_left = 0;
      for (int i = 0; i < QDEPTH; i++) run_q[i] = ID_IDLE;
      for (int i = 0; i < TDEPTH; i++) begin
        tmr_owner[i] = ID_IDLE;
        tmr_left[i] = '0;
      end
    end else begin
      nxt_valid = in_valid;
      if (in_valid && in_ready) begin
        due_results.push_back(schedule_op(cur_op));
        nxt_valid = 1'b0;
        idle_left = (op_backlog.size() != 0) ? op_backlog[0].gap : 0;
      end
      if (!nxt_valid) begin
        if (idle_left != 0) begin
          idle_left--;
        end else if (op_backlog.size() != 0 &&
                     !(op_backlog[0].drain && due_results.size() != 0)) begin
          cur_op = op_backlog.pop_front();
          in_func            <= cur_op.func;
          in_task_id         <= cur_op.id;
          in_delay_ticks     <= cur_op.delay;
          in_update_existing <= cur_op.upd;
          nxt_valid = 1'b1;
        end
      end
      in_valid <= nxt_valid;
    end
  end

  // Take result beats with random stalls and compare against the oldest due one
  always @(posedge clk) begin : result_monitor
    sched_result_t want;
    if (!rst_n) begin
      out_ready <= 1'b0;
      stall_left = 0;
      results_seen = 0;
      steady = 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        results_seen++;
        if (due_results.size() == 0) begin
          report_mismatch($sformatf("result beat with nothing due (run_task %0d)",
                                    out_run_task));
        end else begin
          want = due_results.pop_front();
          if (out_run_task !== want.run_task)
            report_mismatch($sformatf("run_task got %0d want %0d",
                                      out_run_task, want.run_task));
          if (out_accepted !== want.accepted)
            report_mismatch($sformatf("accepted got %0d want %0d",
                                      out_accepted, want.accepted));
          if (out_fired_count !== want.fired)
            report_mismatch($sformatf("fired_count got %0d want %0d",
                                      out_fired_count, want.fired));
        end
        if (results_seen % 100 == 0) steady = ($urandom_range(0, 2) == 0);
        stall_left = steady ? 0 : $urandom_range(0, 9);
        // long hold-off so the block backs up into its input
        if (results_seen == 400) stall_left = 300;
      end else if (stall_left != 0) begin
        stall_left--;
      end
      out_ready <= (stall_left == 0);
    end
  end

  initial begin
    // Directed: empty dispatch, idle ids, full queue, update, expiry
    push_op(FUNC_DISPATCH, 0, 0, 0, $urandom_range(0, 9), 0);
    push_op(FUNC_ADD_TASK, 0, 0, 0, $urandom_range(0, 9), 0);
    push_op(FUNC_ADD_TIMER, 0, 3, 1, $urandom_range(0, 9), 0);
    push_op(FUNC_ADD_TIMER, 8'hFF, 0, 0, $urandom_range(0, 9), 0);
    for (int i = 1; i <= 8; i++) push_op(FUNC_ADD_TASK, i, 0, 0, $urandom_range(0, 9), 0);
    push_op(FUNC_ADD_TASK, 8'hAA, 0, 0, $urandom_range(0, 9), 0);
    push_op(FUNC_ADD_TIMER, 8'h55, 0, 0, $urandom_range(0, 9), 0);
    push_op(FUNC_ADD_TIMER, 8'h55, 1, 0, $urandom_range(0, 9), 0);
    push_op(FUNC_ADD_TIMER, 8'h55, 16'hFFFF, 1, $urandom_range(0, 9), 0);
    push_op(FUNC_ADD_TIMER, 8'h66, 1, 1, $urandom_range(0, 9), 0);
    push_op(FUNC_TICK, 0, 0, 0, $urandom_range(0, 9), 0);
    push_op(FUNC_DISPATCH, 0, 0, 0, $urandom_range(0, 9), 0);
    push_op(FUNC_ADD_TIMER, 8'h55, 2, 1, $urandom_range(0, 9), 0);
    push_op(FUNC_TICK, 0, 0, 0, $urandom_range(0, 9), 0);
    push_op(FUNC_TICK, 0, 0, 0, $urandom_range(0, 9), 0);

    // Random: blocks with a traffic mix each, ids mostly from a small pool
    for (int b = 0; b < 50; b++) begin
      int mode;
      bit burst;
      mode = $urandom_range(0, 3);
      burst = ($urandom_range(0, 3) == 0);
      for (int k = 0; k < 25; k++) begin
        int pick, id, delay;
        func_t f;
        bit upd, drain;
        pick  = $urandom_range(0, 99);
        id    = $urandom_range(1, 12);
        delay = $urandom_range(0, 3);
        upd   = 1'($urandom_range(0, 1));
        drain = (k == 0) && (b == 5 || $urandom_range(0, 3) == 0);
        case (mode)
          0: f = pick < 50 ? FUNC_ADD_TIMER : pick < 80 ? FUNC_TICK :
                 pick < 90 ? FUNC_DISPATCH : FUNC_ADD_TASK;
          1: f = pick < 60 ? FUNC_ADD_TASK : pick < 75 ? FUNC_ADD_TIMER :
                 pick < 90 ? FUNC_TICK : FUNC_DISPATCH;
          2: f = pick < 50 ? FUNC_DISPATCH : pick < 85 ? FUNC_TICK :
                 pick < 95 ? FUNC_ADD_TIMER : FUNC_ADD_TASK;
          default: begin
            f = func_t'($urandom_range(0, 3));
            id = $urandom_range(0, 255);
            delay = $urandom_range(0, 7);
            if (pick < 20) begin
              // long delays stay on pool ids so later updates can reclaim them
              delay = $urandom_range(0, 65535);
              id = $urandom_range(1, 12);
            end else if (pick >= 95) begin
              id = 0;
            end
          end
        endcase
        push_op(f, id, delay, upd, burst ? 0 : $urandom_range(0, 9), drain);
      end
    end

    rst_n = 1'b0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    while (op_backlog.size() != 0 || in_valid) @(posedge clk);
    while (due_results.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
    if (mismatches == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("timeout with %0d results still due", due_results.size());
    $display("status: fail");
    $finish;
  end

endmodule

[sim.f]
rtl/core/tq_pkg.sv
rtl/core/tq_ram.sv
rtl/core/tq_dp.sv
rtl/core/tq_ctrl.sv
rtl/core/task_queue_with_delay_timers_top.sv
dv/testbench.sv
